// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the locker session controller.
// Needs nothing else; every macro takes a label, a clock, an active-low reset and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: rtl/lsc_pkg.sv
// Types and constants of the locker session controller.
// Used by the top level and its checker; depends on nothing.
package lsc_pkg;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_SETPIN  = 3'd1,
		PH_RUNNING = 3'd2,
		PH_UNLOCK  = 3'd3,
		PH_ENDED   = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		CMD_SAMPLE = 3'd0,
		CMD_TICK   = 3'd1,
		CMD_SETPIN = 3'd2,
		CMD_VERIFY = 3'd3,
		CMD_UNLOCK = 3'd4,
		CMD_RESET  = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_WRONG_PH  = 3'd1,
		ST_NON_DIGIT = 3'd2,
		ST_WRONG_PIN = 3'd3,
		ST_REJECTED  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_ZERO_OFFSET = 3'd0,
		REG_THRESHOLD   = 3'd1,
		REG_DETECT      = 3'd2,
		REG_CEILING     = 3'd3,
		REG_RATE        = 3'd4,
		REG_MIN_CHARGE  = 3'd5
	} reg_idx_t;

	localparam int CFG_W = 24;

	localparam logic signed [23:0] ZERO_OFFSET_RST = -24'sd489500;
	localparam logic        [23:0] THRESHOLD_RST   = 24'd3000;
	localparam logic        [7:0]  DETECT_RST      = 8'd10;
	localparam logic signed [23:0] CEILING_RST     = -24'sd100000;
	localparam logic        [9:0]  RATE_RST        = 10'd10;
	localparam logic        [16:0] MIN_CHARGE_RST  = 17'd100;

	localparam logic [23:0] SECS_MAX   = 24'hFFFFFF;
	localparam logic [7:0]  DETECT_MAX = 8'hFF;
	localparam logic [3:0]  DIGIT_MAX  = 4'd9;
	localparam logic [15:0] ROUND_HALF = 16'd30;

	// x / 60 == (x >> 2) / 15, with the /15 as a reciprocal multiply exact for the input width
	localparam logic [22:0] RECIP15_22 = 23'd4473925; // 22-bit input, shift 26
	localparam int          SHIFT15_22 = 26;
	localparam logic [17:0] RECIP15_17 = 18'd139811;  // 17-bit input, shift 21
	localparam int          SHIFT15_17 = 21;
	localparam logic [14:0] RECIP15_14 = 15'd17477;   // 14-bit input, shift 18
	localparam int          SHIFT15_14 = 18;

	typedef struct packed {
		logic [2:0]        command;
		logic signed [23:0] weight_sample;
		logic [15:0]       pin_code;
	} req_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic        door_locked;
		logic [2:0]  status;
		logic [23:0] elapsed_seconds;
		logic [12:0] elapsed_hours;
		logic [5:0]  elapsed_minutes;
		logic [5:0]  elapsed_secs_part;
		logic [28:0] running_rent_pence;
		logic [28:0] final_rent_pence;
		logic        final_valid;
	} rsp_t;

	// per-item flags that ride along the output pipeline
	typedef struct packed {
		phase_t  phase;
		logic    lock;
		status_t status;
		logic    running;
		logic    held;
	} ctl_t;

endpackage

// File: rtl/lsc_stream_if.sv
// Valid/ready channel carrying one payload item per handshake.
// Payload type comes from lsc_pkg through the type parameter.
interface lsc_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/locker_session_controller_unit.sv
// Locker session controller: session state machine plus the elapsed-time and rent pipeline.
// Depends on lsc_pkg and lsc_stream_if.
//
// Channels: req carries one command item (command, weight_sample, pin_code); rsp returns
// exactly one result item per command, in order, showing the state after that command.
// Both are valid/ready; an item moves at a rising edge with valid and ready high.
// Configuration: cfg_wr_en, cfg_index, cfg_data write one register per edge; indexes above
// five are ignored. Write registers only while no command is in flight.
// Throughput: one item per cycle while rsp is not stalled. The session state updates in the
// accept cycle; the following six stages derive minutes, hours, seconds and rent, with one
// multiplier in each of the first five (secs/60, minutes/60, minutes*rate, secpart*rate and
// the /60 of the remainder) and the final add and max in the last.
// When rsp stalls, each stage holds only if the stage after it is full, so req keeps
// taking items until all seven stages are occupied.
// Reset (arst_n low) empties the pipeline, returns the session to idle and unlocked and
// loads the register defaults.
module locker_session_controller_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	lsc_stream_if.sink                  req,
	lsc_stream_if.source                rsp,
	input  logic                        cfg_wr_en,
	input  logic [2:0]                  cfg_index,
	input  logic [lsc_pkg::CFG_W-1:0]   cfg_data
);

	localparam int SHIFT_M = lsc_pkg::SHIFT15_22;

	// configuration registers
	logic signed [23:0] zero_q;
	logic        [23:0] thr_q;
	logic        [7:0]  detect_q;
	logic signed [23:0] ceil_q;
	logic        [9:0]  rate_q;
	logic        [16:0] minc_q;

	// session state
	lsc_pkg::phase_t phase_q, phase_n;
	logic [7:0]  cnt_q, cnt_n;
	logic [15:0] pin_q, pin_n;
	logic [23:0] secs_q, secs_n;
	logic        held_q, held_n;
	logic        lock_q, lock_n;
	logic [9:0]  frate_q, frate_n;
	logic [16:0] fmin_q, fmin_n;
	lsc_pkg::status_t status_n;

	logic        accept;
	logic signed [24:0] drop;
	logic        present;
	logic [7:0]  cnt_inc;
	logic        digits_ok;
	lsc_pkg::req_t rq;

	// pipeline
	logic [7:1] v;
	logic [7:1] en;

	lsc_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic [23:0] secs_s1, secs_s2, secs_s3, secs_s4, secs_s5, secs_s6, secs_s7;
	logic [9:0]  rate_s1, rate_s2, rate_s3, rate_s4;
	logic [16:0] minc_s1, minc_s2, minc_s3, minc_s4, minc_s5, minc_s6;
	logic [18:0] m_s2, m_s3;
	logic [12:0] h_s3, h_s4, h_s5, h_s6, h_s7;
	logic [5:0]  sp_s3, sp_s4, sp_s5, sp_s6, sp_s7;
	logic [5:0]  mins_s4, mins_s5, mins_s6, mins_s7;
	logic [28:0] mr_s4, mr_s5, mr_s6;
	logic [15:0] x_s5;
	logic [9:0]  qx_s6;
	logic [28:0] rent_s7;

	logic [44:0] prod_m;
	logic [34:0] prod_h;
	logic [28:0] prod_q;
	logic [28:0] rent_sum;

	assign rq     = req.data;
	assign accept = req.valid && req.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q   <= lsc_pkg::ZERO_OFFSET_RST;
			thr_q    <= lsc_pkg::THRESHOLD_RST;
			detect_q <= lsc_pkg::DETECT_RST;
			ceil_q   <= lsc_pkg::CEILING_RST;
			rate_q   <= lsc_pkg::RATE_RST;
			minc_q   <= lsc_pkg::MIN_CHARGE_RST;
		end else if (cfg_wr_en) begin
			unique case (lsc_pkg::reg_idx_t'(cfg_index))
				lsc_pkg::REG_ZERO_OFFSET: zero_q   <= $signed(cfg_data[23:0]);
				lsc_pkg::REG_THRESHOLD:   thr_q    <= cfg_data[23:0];
				lsc_pkg::REG_DETECT:      detect_q <= cfg_data[7:0];
				lsc_pkg::REG_CEILING:     ceil_q   <= $signed(cfg_data[23:0]);
				lsc_pkg::REG_RATE:        rate_q   <= cfg_data[9:0];
				lsc_pkg::REG_MIN_CHARGE:  minc_q   <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// presence test at full precision
	assign drop    = {zero_q[23], zero_q} - {rq.weight_sample[23], rq.weight_sample};
	assign present = $signed({drop[24], drop}) > $signed({2'b00, thr_q});
	assign cnt_inc = (cnt_q == lsc_pkg::DETECT_MAX) ? cnt_q : cnt_q + 8'd1;

	always_comb begin
		digits_ok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (rq.pin_code[4*i +: 4] > lsc_pkg::DIGIT_MAX) digits_ok = 1'b0;
		end
	end

	// next session state
	always_comb begin
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		pin_n    = pin_q;
		secs_n   = secs_q;
		held_n   = held_q;
		lock_n   = lock_q;
		frate_n  = frate_q;
		fmin_n   = fmin_q;
		status_n = lsc_pkg::ST_OK;
		unique case (rq.command)
			lsc_pkg::CMD_SAMPLE: begin
				if ($signed(rq.weight_sample) > $signed(ceil_q)) begin
					status_n = lsc_pkg::ST_REJECTED;
				end else if (phase_q == lsc_pkg::PH_IDLE) begin
					if (present) begin
						if (cnt_inc >= detect_q) begin
							phase_n = lsc_pkg::PH_SETPIN;
							cnt_n   = '0;
						end else begin
							cnt_n = cnt_inc;
						end
					end else begin
						cnt_n = '0;
					end
				end
			end
			lsc_pkg::CMD_TICK: begin
				if ((phase_q == lsc_pkg::PH_RUNNING || phase_q == lsc_pkg::PH_UNLOCK) &&
				    secs_q != lsc_pkg::SECS_MAX)
					secs_n = secs_q + 24'd1;
			end
			lsc_pkg::CMD_SETPIN: begin
				if (phase_q != lsc_pkg::PH_SETPIN) begin
					status_n = lsc_pkg::ST_WRONG_PH;
				end else if (!digits_ok) begin
					status_n = lsc_pkg::ST_NON_DIGIT;
				end else begin
					pin_n   = rq.pin_code;
					phase_n = lsc_pkg::PH_RUNNING;
					secs_n  = '0;
					held_n  = 1'b0;
					lock_n  = 1'b1;
				end
			end
			lsc_pkg::CMD_VERIFY: begin
				if (phase_q != lsc_pkg::PH_UNLOCK) begin
					status_n = lsc_pkg::ST_WRONG_PH;
				end else if (rq.pin_code != pin_q) begin
					status_n = lsc_pkg::ST_WRONG_PIN;
				end else begin
					// freeze the tariff; the rent itself is derived downstream
					frate_n = rate_q;
					fmin_n  = minc_q;
					held_n  = 1'b1;
					pin_n   = '0;
					phase_n = lsc_pkg::PH_ENDED;
					lock_n  = 1'b0;
				end
			end
			lsc_pkg::CMD_UNLOCK: begin
				if (phase_q == lsc_pkg::PH_RUNNING) phase_n = lsc_pkg::PH_UNLOCK;
				else status_n = lsc_pkg::ST_WRONG_PH;
			end
			lsc_pkg::CMD_RESET: begin
				if (phase_q == lsc_pkg::PH_ENDED) begin
					phase_n = lsc_pkg::PH_IDLE;
					held_n  = 1'b0;
					secs_n  = '0;
					cnt_n   = '0;
				end else begin
					status_n = lsc_pkg::ST_WRONG_PH;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lsc_pkg::PH_IDLE;
			cnt_q   <= '0;
			pin_q   <= '0;
			secs_q  <= '0;
			held_q  <= 1'b0;
			lock_q  <= 1'b0;
			frate_q <= '0;
			fmin_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			pin_q   <= pin_n;
			secs_q  <= secs_n;
			held_q  <= held_n;
			lock_q  <= lock_n;
			frate_q <= frate_n;
			fmin_q  <= fmin_n;
		end
	end

	// stage enables: a stage loads when empty or when the stage after it moves
	assign en[7]     = !v[7] || rsp.ready;
	assign en[6:1]   = ~v[6:1] | en[7:2];
	assign req.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1]) v[1] <= req.valid;
			for (int k = 2; k <= 7; k++) begin
				if (en[k]) v[k] <= v[k-1];
			end
		end
	end

	// stage arithmetic
	assign prod_m   = 45'(secs_s1[23:2]) * 45'(lsc_pkg::RECIP15_22);
	assign prod_h   = 35'(m_s2[18:2]) * 35'(lsc_pkg::RECIP15_17);
	assign prod_q   = 29'(x_s5[15:2]) * 29'(lsc_pkg::RECIP15_14);
	assign rent_sum = mr_s6 + 29'(qx_s6);

	// s1: snapshot of the state after the item
	always_ff @(posedge clk) begin
		if (en[1]) begin
			ctl_s1.phase   <= phase_n;
			ctl_s1.lock    <= lock_n;
			ctl_s1.status  <= status_n;
			ctl_s1.running <= (phase_n == lsc_pkg::PH_RUNNING);
			ctl_s1.held    <= held_n;
			secs_s1        <= secs_n;
			rate_s1        <= (phase_n == lsc_pkg::PH_RUNNING) ? rate_q : frate_n;
			minc_s1        <= (phase_n == lsc_pkg::PH_RUNNING) ? minc_q : fmin_n;
		end
	end

	// s2: whole minutes
	always_ff @(posedge clk) begin
		if (en[2]) begin
			ctl_s2  <= ctl_s1;
			secs_s2 <= secs_s1;
			rate_s2 <= rate_s1;
			minc_s2 <= minc_s1;
			m_s2    <= prod_m[SHIFT_M +: 19];
		end
	end

	// s3: hours; seconds part is secs - 60*m, exact in six bits
	always_ff @(posedge clk) begin
		if (en[3]) begin
			ctl_s3  <= ctl_s2;
			secs_s3 <= secs_s2;
			rate_s3 <= rate_s2;
			minc_s3 <= minc_s2;
			m_s3    <= m_s2;
			h_s3    <= prod_h[lsc_pkg::SHIFT15_17 +: 13];
			sp_s3   <= secs_s2[5:0] + {m_s2[3:0], 2'b00};
		end
	end

	// s4: minutes within the hour, whole-minute rent
	always_ff @(posedge clk) begin
		if (en[4]) begin
			ctl_s4  <= ctl_s3;
			secs_s4 <= secs_s3;
			rate_s4 <= rate_s3;
			minc_s4 <= minc_s3;
			h_s4    <= h_s3;
			sp_s4   <= sp_s3;
			mins_s4 <= m_s3[5:0] + {h_s3[3:0], 2'b00};
			mr_s4   <= 29'(m_s3) * 29'(rate_s3);
		end
	end

	// s5: leftover seconds times rate, plus half a penny
	always_ff @(posedge clk) begin
		if (en[5]) begin
			ctl_s5  <= ctl_s4;
			secs_s5 <= secs_s4;
			minc_s5 <= minc_s4;
			h_s5    <= h_s4;
			sp_s5   <= sp_s4;
			mins_s5 <= mins_s4;
			mr_s5   <= mr_s4;
			x_s5    <= 16'(sp_s4) * 16'(rate_s4) + lsc_pkg::ROUND_HALF;
		end
	end

	// s6: divide the leftover by 60
	always_ff @(posedge clk) begin
		if (en[6]) begin
			ctl_s6  <= ctl_s5;
			secs_s6 <= secs_s5;
			minc_s6 <= minc_s5;
			h_s6    <= h_s5;
			sp_s6   <= sp_s5;
			mins_s6 <= mins_s5;
			mr_s6   <= mr_s5;
			qx_s6   <= prod_q[lsc_pkg::SHIFT15_14 +: 10];
		end
	end

	// s7: result register; apply the minimum charge
	always_ff @(posedge clk) begin
		if (en[7]) begin
			ctl_s7  <= ctl_s6;
			secs_s7 <= secs_s6;
			h_s7    <= h_s6;
			sp_s7   <= sp_s6;
			mins_s7 <= mins_s6;
			rent_s7 <= (rent_sum < 29'(minc_s6)) ? 29'(minc_s6) : rent_sum;
		end
	end

	assign rsp.valid                   = v[7];
	assign rsp.data.phase              = ctl_s7.phase;
	assign rsp.data.door_locked        = ctl_s7.lock;
	assign rsp.data.status             = ctl_s7.status;
	assign rsp.data.elapsed_seconds    = secs_s7;
	assign rsp.data.elapsed_hours      = h_s7;
	assign rsp.data.elapsed_minutes    = mins_s7;
	assign rsp.data.elapsed_secs_part  = sp_s7;
	assign rsp.data.running_rent_pence = ctl_s7.running ? rent_s7 : '0;
	assign rsp.data.final_rent_pence   = ctl_s7.held ? rent_s7 : '0;
	assign rsp.data.final_valid        = ctl_s7.held;

endmodule

// File: rtl/lsc_checker.sv
// Port-level checks on the result channel of the locker session controller.
// Depends on lsc_pkg and assert_macros.svh; bound to the top level at the end of this file.
`include "assert_macros.svh"

module lsc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input lsc_pkg::rsp_t out_data
);

	`ASSERT_NEXT(a_hold_stalled, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data), "result item changed while stalled")

	`ASSERT_IMPL(a_lock_phase, clk, arst_n, out_valid,
		out_data.door_locked == (out_data.phase == lsc_pkg::PH_RUNNING ||
		out_data.phase == lsc_pkg::PH_UNLOCK), "door lock disagrees with phase")

	`ASSERT_IMPL(a_final_zero, clk, arst_n, out_valid && !out_data.final_valid,
		out_data.final_rent_pence == '0, "final rent shown without an ended session")

	`ASSERT_IMPL(a_running_rent, clk, arst_n, out_valid && out_data.phase != lsc_pkg::PH_RUNNING,
		out_data.running_rent_pence == '0, "running rent outside the running phase")

	`ASSERT_IMPL(a_time_split, clk, arst_n, out_valid,
		out_data.elapsed_minutes < 6'd60 && out_data.elapsed_secs_part < 6'd60,
		"elapsed time split out of range")

endmodule

bind locker_session_controller_unit lsc_checker u_lsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_data  (rsp.data)
);
